### hdl/dssc_pkg.sv
package dssc_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 18;
	localparam int STATE_W    = 40;
	localparam int LO_W       = STATE_W / 2;
	localparam int OPND_W     = LO_W + 1;
	localparam int PROD_W     = COEF_W + OPND_W;
	localparam int ACC_W      = 64;
	localparam int FRAC_SHIFT = 16;
	localparam int SHIFT_W    = $clog2(LO_W + 2);
	localparam int NUM_OPS    = 13;
	localparam int CNT_W      = $clog2(NUM_OPS + 1);
	localparam int REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_POLE_REAL     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_POLE_IMAG     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_OUT_COEF_REAL = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_OUT_COEF_IMAG = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SKIP_GAIN     = 3'd4;

	typedef struct packed {
		logic signed [COEF_W-1:0] pole_real;
		logic signed [COEF_W-1:0] pole_imag;
		logic signed [COEF_W-1:0] out_coef_real;
		logic signed [COEF_W-1:0] out_coef_imag;
		logic signed [COEF_W-1:0] skip_gain;
	} cfg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       seq_start;
	} item_t;

	typedef enum logic [2:0] {
		C_AR = 3'd0,
		C_AI = 3'd1,
		C_CR = 3'd2,
		C_CI = 3'd3,
		C_D  = 3'd4
	} coef_sel_t;

	typedef enum logic [2:0] {
		O_XR = 3'd0,
		O_XI = 3'd1,
		O_HR = 3'd2,
		O_HI = 3'd3,
		O_U  = 3'd4
	} opnd_sel_t;

	typedef struct packed {
		coef_sel_t           coef;
		opnd_sel_t           opnd;
		logic                hi;
		logic [SHIFT_W-1:0]  shift;
		logic                neg;
		logic                first;
	} op_t;

	localparam logic [SHIFT_W-1:0] SH_LO    = '0;
	localparam logic [SHIFT_W-1:0] SH_HI    = SHIFT_W'(LO_W);
	localparam logic [SHIFT_W-1:0] SH_LO_X2 = SHIFT_W'(1);
	localparam logic [SHIFT_W-1:0] SH_HI_X2 = SHIFT_W'(LO_W + 1);

	// partial product schedule: p = ar*xr - ai*xi, q = ar*xi + ai*xr,
	// s = 2*(cr*hr - ci*hi) + d*u
	function automatic op_t op_decode(input logic [CNT_W-1:0] idx);
		op_t op;
		unique case (idx)
			4'd0:    op = '{C_AR, O_XR, 1'b0, SH_LO,    1'b0, 1'b1};
			4'd1:    op = '{C_AR, O_XR, 1'b1, SH_HI,    1'b0, 1'b0};
			4'd2:    op = '{C_AI, O_XI, 1'b0, SH_LO,    1'b1, 1'b0};
			4'd3:    op = '{C_AI, O_XI, 1'b1, SH_HI,    1'b1, 1'b0};
			4'd4:    op = '{C_AR, O_XI, 1'b0, SH_LO,    1'b0, 1'b1};
			4'd5:    op = '{C_AR, O_XI, 1'b1, SH_HI,    1'b0, 1'b0};
			4'd6:    op = '{C_AI, O_XR, 1'b0, SH_LO,    1'b0, 1'b0};
			4'd7:    op = '{C_AI, O_XR, 1'b1, SH_HI,    1'b0, 1'b0};
			4'd8:    op = '{C_CR, O_HR, 1'b0, SH_LO_X2, 1'b0, 1'b1};
			4'd9:    op = '{C_CR, O_HR, 1'b1, SH_HI_X2, 1'b0, 1'b0};
			4'd10:   op = '{C_CI, O_HI, 1'b0, SH_LO_X2, 1'b1, 1'b0};
			4'd11:   op = '{C_CI, O_HI, 1'b1, SH_HI_X2, 1'b1, 1'b0};
			4'd12:   op = '{C_D,  O_U,  1'b0, SH_LO,    1'b0, 1'b0};
			default: op = '{C_AR, O_XR, 1'b0, SH_LO,    1'b0, 1'b1};
		endcase
		return op;
	endfunction

endpackage

### hdl/dssc_front.sv
module dssc_front (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         push,
	output logic                                         full,
	input  logic signed [dssc_pkg::SAMPLE_W-1:0]         sample_in,
	input  logic                                         seq_start,
	output logic                                         item_valid,
	output dssc_pkg::item_t                              item,
	input  logic                                         item_take
);

	dssc_pkg::item_t q_mem [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            push_ok;
	logic            take_ok;

	assign full       = (count_q == 2'd2);
	assign item_valid = (count_q != 2'd0);
	assign item       = q_mem[rd_ptr_q];
	assign push_ok    = push && !full;
	assign take_ok    = item_take && item_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (take_ok) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push_ok && !take_ok) begin
				count_q <= count_q + 2'd1;
			end else if (!push_ok && take_ok) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			q_mem[wr_ptr_q] <= '{sample: sample_in, seq_start: seq_start};
		end
	end

endmodule

### hdl/dssc_back.sv
module dssc_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dssc_pkg::cfg_t                       cfg,
	input  logic                                 item_valid,
	input  dssc_pkg::item_t                      item,
	output logic                                 item_take,
	output logic                                 empty,
	input  logic                                 pop,
	output logic signed [dssc_pkg::SAMPLE_W-1:0] sample_out
);

	localparam int SAMPLE_W = dssc_pkg::SAMPLE_W;
	localparam int COEF_W   = dssc_pkg::COEF_W;
	localparam int STATE_W  = dssc_pkg::STATE_W;
	localparam int LO_W     = dssc_pkg::LO_W;
	localparam int OPND_W   = dssc_pkg::OPND_W;
	localparam int PROD_W   = dssc_pkg::PROD_W;
	localparam int ACC_W    = dssc_pkg::ACC_W;
	localparam int CNT_W    = dssc_pkg::CNT_W;
	localparam int SHIFT_W  = dssc_pkg::SHIFT_W;

	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (dssc_pkg::FRAC_SHIFT - 1);
	localparam logic [CNT_W-1:0] CNT_LAST    = CNT_W'(dssc_pkg::NUM_OPS);
	localparam logic [CNT_W-1:0] CNT_FIN_P   = CNT_W'(5);
	localparam logic [CNT_W-1:0] CNT_FIN_Q   = CNT_W'(9);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-STATE_W:0] top;
		top = v[ACC_W-1:STATE_W-1];
		if (&top || !(|top)) begin
			return v[STATE_W-1:0];
		end else if (v[ACC_W-1]) begin
			return {1'b1, {(STATE_W-1){1'b0}}};
		end else begin
			return {1'b0, {(STATE_W-1){1'b1}}};
		end
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-SAMPLE_W:0] top;
		top = v[ACC_W-1:SAMPLE_W-1];
		if (&top || !(|top)) begin
			return v[SAMPLE_W-1:0];
		end else if (v[ACC_W-1]) begin
			return {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			return {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	endfunction

	state_t                       state_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         pv_s1;
	logic                         out_full_q;
	logic signed [STATE_W-1:0]    xr_q;
	logic signed [STATE_W-1:0]    xi_q;
	logic signed [STATE_W-1:0]    hr_new_q;
	logic signed [STATE_W-1:0]    hi_new_q;
	logic signed [SAMPLE_W-1:0]   u_q;
	logic signed [SAMPLE_W-1:0]   out_q;
	logic signed [PROD_W-1:0]     prod_s1;
	logic [SHIFT_W-1:0]           shift_s1;
	logic                         neg_s1;
	logic                         first_s1;
	logic signed [ACC_W-1:0]      acc_q;

	dssc_pkg::op_t                op;
	logic                         issue;
	logic signed [COEF_W-1:0]     coef_mux;
	logic signed [STATE_W-1:0]    state_mux;
	logic signed [OPND_W-1:0]     opnd_mux;
	logic signed [PROD_W-1:0]     prod_c;
	logic signed [ACC_W-1:0]      term_c;
	logic signed [ACC_W-1:0]      signed_term_c;
	logic signed [ACC_W-1:0]      rnd_c;
	logic signed [STATE_W-1:0]    hr_sat_c;
	logic signed [STATE_W-1:0]    hi_sat_c;
	logic signed [SAMPLE_W-1:0]   y_sat_c;
	logic                         write_out;

	assign item_take  = (state_q == ST_IDLE) && item_valid;
	assign empty      = !out_full_q;
	assign sample_out = out_q;
	assign write_out  = (state_q == ST_FIN) && !out_full_q;
	assign issue      = (state_q == ST_RUN) && (cnt_q < CNT_LAST);
	assign op         = dssc_pkg::op_decode(cnt_q);

	always_comb begin
		case (op.coef)
			dssc_pkg::C_AR: coef_mux = cfg.pole_real;
			dssc_pkg::C_AI: coef_mux = cfg.pole_imag;
			dssc_pkg::C_CR: coef_mux = cfg.out_coef_real;
			dssc_pkg::C_CI: coef_mux = cfg.out_coef_imag;
			dssc_pkg::C_D:  coef_mux = cfg.skip_gain;
			default:        coef_mux = '0;
		endcase
		case (op.opnd)
			dssc_pkg::O_XR: state_mux = xr_q;
			dssc_pkg::O_XI: state_mux = xi_q;
			dssc_pkg::O_HR: state_mux = hr_new_q;
			dssc_pkg::O_HI: state_mux = hi_new_q;
			default:        state_mux = '0;
		endcase
		if (op.opnd == dssc_pkg::O_U) begin
			opnd_mux = OPND_W'(u_q);
		end else if (op.hi) begin
			opnd_mux = OPND_W'($signed(state_mux[STATE_W-1:LO_W]));
		end else begin
			opnd_mux = $signed({1'b0, state_mux[LO_W-1:0]});
		end
	end

	assign prod_c        = coef_mux * opnd_mux;
	assign term_c        = ACC_W'(prod_s1) <<< shift_s1;
	assign signed_term_c = neg_s1 ? -term_c : term_c;
	assign rnd_c         = (acc_q + ROUND_HALF) >>> dssc_pkg::FRAC_SHIFT;
	assign hr_sat_c      = sat_state(rnd_c + ACC_W'(u_q));
	assign hi_sat_c      = sat_state(rnd_c);
	assign y_sat_c       = sat_sample(rnd_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			pv_s1      <= 1'b0;
			out_full_q <= 1'b0;
			xr_q       <= '0;
			xi_q       <= '0;
		end else begin
			pv_s1 <= issue;
			if (pop && out_full_q) begin
				out_full_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						cnt_q   <= '0;
						state_q <= ST_RUN;
						if (item.seq_start) begin
							xr_q <= '0;
							xi_q <= '0;
						end
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (write_out) begin
						out_full_q <= 1'b1;
						xr_q       <= hr_new_q;
						xi_q       <= hi_new_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			u_q <= item.sample;
		end
		if (issue) begin
			prod_s1  <= prod_c;
			shift_s1 <= op.shift;
			neg_s1   <= op.neg;
			first_s1 <= op.first;
		end
		if (pv_s1) begin
			acc_q <= first_s1 ? signed_term_c : acc_q + signed_term_c;
		end
		if (state_q == ST_RUN && cnt_q == CNT_FIN_P) begin
			hr_new_q <= hr_sat_c;
		end
		if (state_q == ST_RUN && cnt_q == CNT_FIN_Q) begin
			hi_new_q <= hi_sat_c;
		end
		if (write_out) begin
			out_q <= y_sat_c;
		end
	end

endmodule

### hdl/diagonal_state_space_channel_unit.sv
// One channel of a diagonal complex state-space layer. Each input sample u
// updates the complex state x = a*x + u (cleared first when seq_start is set)
// and gives one output y = 2*Re(c*x) + d*u, rounded and saturated to Q3.12.
// The pole a, the coefficient c and the gain d are signed Q1.16 registers,
// reset to zero; the user must write them only while the block is idle, and
// the block does not enforce this. Writes to other indices are dropped.
// A sample passes through a load step, thirteen partial products issued
// through a single 18x21 multiplier into a 64-bit accumulator plus a final
// accumulate, and a result write. A two-entry input queue and a one-entry
// result register let new samples enter while a result waits to be popped.
module diagonal_state_space_channel_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic signed [dssc_pkg::SAMPLE_W-1:0]  sample_in,
	input  logic                                  seq_start,
	output logic                                  empty,
	input  logic                                  pop,
	output logic signed [dssc_pkg::SAMPLE_W-1:0]  sample_out,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [dssc_pkg::REG_IDX_W-1:0]        cfg_index,
	input  logic [dssc_pkg::COEF_W-1:0]           cfg_data
);

	dssc_pkg::cfg_t  cfg_q;
	dssc_pkg::item_t item;
	logic            item_valid;
	logic            item_take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				dssc_pkg::REG_POLE_REAL:     cfg_q.pole_real     <= $signed(cfg_data);
				dssc_pkg::REG_POLE_IMAG:     cfg_q.pole_imag     <= $signed(cfg_data);
				dssc_pkg::REG_OUT_COEF_REAL: cfg_q.out_coef_real <= $signed(cfg_data);
				dssc_pkg::REG_OUT_COEF_IMAG: cfg_q.out_coef_imag <= $signed(cfg_data);
				dssc_pkg::REG_SKIP_GAIN:     cfg_q.skip_gain     <= $signed(cfg_data);
				default: begin
				end
			endcase
		end
	end

	dssc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.sample_in  (sample_in),
		.seq_start  (seq_start),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take)
	);

	dssc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.empty      (empty),
		.pop        (pop),
		.sample_out (sample_out)
	);

endmodule

### hdl/dssc_checker.sv
module dssc_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 push,
	input logic                                 full,
	input logic                                 empty,
	input logic                                 pop,
	input logic signed [dssc_pkg::SAMPLE_W-1:0] sample_out
);

	// a waiting result holds until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(sample_out)))
		else $error("result changed or vanished before its transfer");

	// single result register: a transfer always leaves it empty
	a_out_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop) |=> empty)
		else $error("result register not empty after transfer");

	// input queue fills only through an input transfer
	a_full_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("input queue became full without a push");

endmodule

bind diagonal_state_space_channel_unit dssc_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.push       (push),
	.full       (full),
	.empty      (empty),
	.pop        (pop),
	.sample_out (sample_out)
);

### bench/diagonal_state_space_channel_unit_tb.sv
module diagonal_state_space_channel_unit_tb;
	import dssc_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 38;
	localparam logic [REG_IDX_W-1:0] REG_LAST = REG_SKIP_GAIN;
	localparam logic [REG_IDX_W-1:0] REG_TOP  = {REG_IDX_W{1'b1}};

	class channel_tracker;
		logic signed [COEF_W-1:0] pole_re, pole_im, coef_re, coef_im, skip;
		longint hid_re, hid_im;
		logic signed [SAMPLE_W-1:0] pending_outputs[$];
		int errors, checked, samples;

		function new();
			pole_re = '0;
			pole_im = '0;
			coef_re = '0;
			coef_im = '0;
			skip = '0;
			hid_re = 0;
			hid_im = 0;
			errors = 0;
			checked = 0;
			samples = 0;
		endfunction

		function void write_reg(logic [REG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
			case (idx)
				REG_POLE_REAL: pole_re = data;
				REG_POLE_IMAG: pole_im = data;
				REG_OUT_COEF_REAL: coef_re = data;
				REG_OUT_COEF_IMAG: coef_im = data;
				REG_SKIP_GAIN: skip = data;
				default: ;
			endcase
		endfunction

		function longint round_q16(longint v);
			longint half;
			half = longint'(1) <<< (FRAC_SHIFT - 1);
			return (v + half) >>> FRAC_SHIFT;
		endfunction

		function longint clamp(longint v, int w);
			longint hi, lo;
			hi = (longint'(1) <<< (w - 1)) - 1;
			lo = -hi - 1;
			if (v > hi) return hi;
			if (v < lo) return lo;
			return v;
		endfunction

		function void take_sample(logic signed [SAMPLE_W-1:0] u, logic start);
			longint xr, xi, p, q, s, ul;
			ul = longint'(u);
			xr = start ? 0 : hid_re;
			xi = start ? 0 : hid_im;
			p = longint'(pole_re) * xr - longint'(pole_im) * xi;
			q = longint'(pole_re) * xi + longint'(pole_im) * xr;
			hid_re = clamp(round_q16(p) + ul, STATE_W);
			hid_im = clamp(round_q16(q), STATE_W);
			s = 2 * (longint'(coef_re) * hid_re - longint'(coef_im) * hid_im)
				+ longint'(skip) * ul;
			pending_outputs.push_back(SAMPLE_W'(clamp(round_q16(s), SAMPLE_W)));
			samples++;
		endfunction

		function void check_output(logic signed [SAMPLE_W-1:0] got);
			logic signed [SAMPLE_W-1:0] want;
			if (pending_outputs.size() == 0) begin
				$display("%0t sample_out with nothing pending: expected none, got %0d",
					$time, got);
				errors++;
				return;
			end
			want = pending_outputs.pop_front();
			checked++;
			if (got !== want) begin
				$display("%0t sample_out mismatch: expected %0d, got %0d", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic signed [SAMPLE_W-1:0] sample_in = '0;
	logic seq_start = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [COEF_W-1:0] cfg_data = '0;

	channel_tracker tracker = new();
	bit send_steady = 1'b0;
	bit pop_steady = 1'b0;
	int pop_hold = 0;
	int cycles = 0;
	int settings = 0;

	diagonal_state_space_channel_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.sample_in(sample_in),
		.seq_start(seq_start),
		.empty(empty),
		.pop(pop),
		.sample_out(sample_out),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic int pick_gap(bit steady);
		int r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			tracker.check_output(sample_out);
		if (pop_hold > 0) begin
			pop_hold--;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
			pop_hold = pick_gap(pop_steady);
		end
	end

	task automatic send_item(input logic signed [SAMPLE_W-1:0] u, input logic start);
		int gap;
		gap = pick_gap(send_steady);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		sample_in <= u;
		seq_start <= start;
		do @(posedge clk); while (full);
		tracker.take_sample(u, start);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		tracker.write_reg(idx, data);
	endtask

	task automatic load_cfg(input cfg_t c, input bit stray);
		if (stray)
			write_reg(REG_IDX_W'($urandom_range(REG_TOP, REG_LAST + 1)), COEF_W'($urandom));
		write_reg(REG_POLE_REAL, c.pole_real);
		write_reg(REG_POLE_IMAG, c.pole_imag);
		write_reg(REG_OUT_COEF_REAL, c.out_coef_real);
		write_reg(REG_OUT_COEF_IMAG, c.out_coef_imag);
		write_reg(REG_SKIP_GAIN, c.skip_gain);
		cfg_valid <= 1'b0;
		settings++;
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (tracker.pending_outputs.size() != 0) @(posedge clk);
	endtask

	function automatic logic [COEF_W-1:0] pick_coef(int kind, bit is_pole);
		int r;
		case (kind)
			0: begin
				if (is_pole)
					return COEF_W'(int'($urandom_range(0, 124000)) - 62000);
				return COEF_W'($urandom);
			end
			1: return COEF_W'($urandom);
			default: begin
				r = $urandom_range(0, 3);
				if (r == 0) return {1'b0, {(COEF_W-1){1'b1}}};
				if (r == 1) return {1'b1, {(COEF_W-1){1'b0}}};
				if (r == 2) return '0;
				return COEF_W'(1);
			end
		endcase
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return SAMPLE_W'($urandom);
		if (r < 85) return SAMPLE_W'(int'($urandom_range(0, 1024)) - 512);
		return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
	endfunction

	initial begin
		cfg_t c;
		int n, len, kind;
		logic start;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers still at reset, output must stay zero
		send_item(16'sh7fff, 1'b1);
		send_item(16'sh8000, 1'b0);
		drain();

		c = '{pole_real: 18'sd58982, pole_imag: 18'sd19661, out_coef_real: 18'sd32768,
			out_coef_imag: -18'sd16384, skip_gain: 18'sd65536};
		load_cfg(c, 1'b1);
		send_item(16'sh7fff, 1'b1);
		send_item(16'sh7fff, 1'b0);
		send_item(16'sh8000, 1'b1);
		send_item(16'sh8000, 1'b0);
		send_item(16'sh0000, 1'b1);
		send_item(16'sh0001, 1'b0);
		send_item(16'sh5555, 1'b0);
		send_item(16'shaaaa, 1'b0);
		drain();

		// largest pole: state and output run into saturation
		c = '{pole_real: 18'sd131071, pole_imag: 18'sd131071, out_coef_real: 18'sd131071,
			out_coef_imag: 18'sd131071, skip_gain: 18'sd131071};
		load_cfg(c, 1'b0);
		send_item(16'sh7fff, 1'b1);
		for (int k = 0; k < 17; k++)
			send_item(16'sh7fff, 1'b0);
		drain();

		c = '{pole_real: -18'sd131072, pole_imag: -18'sd131072, out_coef_real: -18'sd131072,
			out_coef_imag: -18'sd131072, skip_gain: -18'sd131072};
		load_cfg(c, 1'b1);
		send_item(16'sh8000, 1'b1);
		send_item(16'sh7fff, 1'b0);
		send_item(16'sh8000, 1'b0);
		send_item(16'shffff, 1'b1);
		drain();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			kind = ph % 3;
			c.pole_real = pick_coef(kind, 1'b1);
			c.pole_imag = pick_coef(kind, 1'b1);
			c.out_coef_real = pick_coef(kind, 1'b0);
			c.out_coef_imag = pick_coef(kind, 1'b0);
			c.skip_gain = pick_coef(kind, 1'b0);
			send_steady = (ph == 0) || ($urandom_range(0, 3) == 0);
			pop_steady = (ph == 0) || ($urandom_range(0, 3) == 0);
			load_cfg(c, $urandom_range(0, 1));
			n = 0;
			while (n < PHASE_ITEMS) begin
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
				for (int k = 0; k < len; k++) begin
					start = (k == 0);
					// stray sequence marks mid-sequence, and missing ones
					if ($urandom_range(0, 99) < 5)
						start = ~start;
					send_item(pick_sample(), start);
					n++;
				end
			end
			drain();
		end

		send_steady = 1'b0;
		pop_steady = 1'b0;
		repeat (40) @(posedge clk);
		if (tracker.pending_outputs.size() != 0) begin
			$display("%0t %0d outputs never arrived", $time, tracker.pending_outputs.size());
			tracker.errors++;
		end
		$display("%0d samples sent under %0d register settings, %0d outputs checked",
			tracker.samples, settings, tracker.checked);
		$display("covered reset values, saturating poles, sequence restarts and stray writes");
		if (tracker.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### diagonal_state_space_channel_unit.f
hdl/dssc_pkg.sv
hdl/dssc_front.sv
hdl/dssc_back.sv
hdl/diagonal_state_space_channel_unit.sv
hdl/dssc_checker.sv
bench/diagonal_state_space_channel_unit_tb.sv
